/* rtl/lpfd_pkg.sv */
`default_nettype none
package lpfd_pkg;

	localparam int unsigned HDR_BYTES   = 16;
	localparam int unsigned STORE_BYTES = HDR_BYTES - 1;
	localparam int unsigned STORE_BITS  = 8 * STORE_BYTES;
	localparam int unsigned HDR_BITS    = 8 * HDR_BYTES;

	// 'P' 'M' 'T' '2'
	localparam logic [31:0] MAGIC = {8'h50, 8'h4D, 8'h54, 8'h32};

	localparam logic [2:0] REG_EXPECTED_VERSION = 3'd0;
	localparam logic [2:0] REG_PAYLOAD_LIMIT    = 3'd1;
	localparam logic [2:0] REG_RESPONSE_BIT     = 3'd2;
	localparam logic [2:0] REG_ERROR_BIT        = 3'd3;
	localparam logic [2:0] REG_STREAM_BIT       = 3'd4;
	localparam logic [2:0] REG_MORE_BIT         = 3'd5;

	localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd2;
	localparam logic [31:0] RST_PAYLOAD_LIMIT    = 32'd16777216;
	localparam logic [7:0]  RST_RESPONSE_BIT     = 8'd1;
	localparam logic [7:0]  RST_ERROR_BIT        = 8'd2;
	localparam logic [7:0]  RST_STREAM_BIT       = 8'd4;
	localparam logic [7:0]  RST_MORE_BIT         = 8'd8;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC   = 2'd0,
		ERR_VERSION = 2'd1,
		ERR_FLAGS   = 2'd2,
		ERR_LENGTH  = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0]  expected_version;
		logic [31:0] payload_limit;
		logic [7:0]  response_bit;
		logic [7:0]  error_bit;
		logic [7:0]  stream_bit;
		logic [7:0]  more_bit;
	} cfg_t;

	typedef struct packed {
		logic        fail;
		err_t        code;
		logic [7:0]  flags;
		logic [15:0] msg_type;
		logic [31:0] req_id;
		logic [31:0] length;
	} chk_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [7:0]  msg_flags;
		logic [15:0] msg_type;
		logic [31:0] req_id;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic        last_of_message;
		err_t        error_code;
	} result_t;

endpackage
`default_nettype wire

/* rtl/lpfd_in_if.sv */
`default_nettype none
interface lpfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/lpfd_out_if.sv */
`default_nettype none
interface lpfd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [7:0]  msg_flags;
	logic [15:0] msg_type;
	logic [31:0] req_id;
	logic [31:0] payload_length;
	logic [7:0]  payload_byte;
	logic        last_of_message;
	logic [1:0]  error_code;

	modport source (
		output valid, output item_kind, output msg_flags, output msg_type,
		output req_id, output payload_length, output payload_byte,
		output last_of_message, output error_code, input ready
	);
	modport sink (
		input valid, input item_kind, input msg_flags, input msg_type,
		input req_id, input payload_length, input payload_byte,
		input last_of_message, input error_code, output ready
	);
endinterface
`default_nettype wire

/* rtl/lpfd_hdr_check.sv */
`default_nettype none
// Header field split and validity checks, first failing check wins.
module lpfd_hdr_check (
	input  wire logic [lpfd_pkg::HDR_BITS-1:0] hdr,
	input  wire lpfd_pkg::cfg_t                cfg,
	output lpfd_pkg::chk_t                     chk
);
	logic [31:0] magic;
	logic [7:0]  version;
	logic [7:0]  flags;
	logic [7:0]  allowed;
	logic        flags_bad;

	assign magic   = hdr[127:96];
	assign version = hdr[95:88];
	assign flags   = hdr[87:80];
	assign allowed = cfg.response_bit | cfg.error_bit | cfg.stream_bit | cfg.more_bit;

	assign flags_bad = (|(flags & ~allowed))
		|| ((|(flags & cfg.error_bit)) && !(|(flags & cfg.response_bit)))
		|| ((|(flags & cfg.more_bit)) && !(|(flags & cfg.stream_bit)));

	always_comb begin
		chk.flags      = flags;
		chk.msg_type   = hdr[79:64];
		chk.req_id     = hdr[63:32];
		chk.length     = hdr[31:0];
		chk.fail       = 1'b1;
		if (magic != lpfd_pkg::MAGIC) begin
			chk.code = lpfd_pkg::ERR_MAGIC;
		end else if (version != cfg.expected_version) begin
			chk.code = lpfd_pkg::ERR_VERSION;
		end else if (flags_bad) begin
			chk.code = lpfd_pkg::ERR_FLAGS;
		end else if (hdr[31:0] > cfg.payload_limit) begin
			chk.code = lpfd_pkg::ERR_LENGTH;
		end else begin
			chk.code = lpfd_pkg::ERR_MAGIC;
			chk.fail = 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/length_prefixed_frame_deframer.sv */
// Each result word is registered (main or skid register) before it appears on dout.
// Throughput: one input word per cycle; a two-deep output register (main + skid)
// keeps din.ready high while one result waits, so only a sustained dout stall stops input.
// Header bytes 1..15 are only stored; the header check runs in the cycle of byte 16.
// Reset (arst_n low, asynchronous): control and config registers reset, deframer
// re-enters header phase, output empties; after an error nothing is output until reset.
`default_nettype none
module length_prefixed_frame_deframer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	lpfd_in_if.sink           din,
	lpfd_out_if.source        dout
);
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_BLOCKED
	} phase_t;

	phase_t                            phase_q;
	logic [3:0]                        count_q;
	logic [31:0]                       left_q;
	logic [lpfd_pkg::STORE_BITS-1:0]   store_q;
	lpfd_pkg::cfg_t                    cfg_q;

	logic              out_v_q, skid_v_q;
	lpfd_pkg::result_t out_q, skid_q;

	logic              in_fire;
	logic              res_v;
	lpfd_pkg::result_t res;
	lpfd_pkg::chk_t    chk;
	logic              hdr_done;

	assign in_fire  = din.valid && din.ready;
	assign din.ready = !skid_v_q;
	assign hdr_done = (phase_q == PH_HEADER)
		&& (count_q == 4'(lpfd_pkg::STORE_BYTES));

	lpfd_hdr_check u_check (
		.hdr ({store_q, din.data_byte}),
		.cfg (cfg_q),
		.chk (chk)
	);

	always_comb begin
		res       = '0;
		res_v     = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				res_v                = 1'b1;
				res.item_kind        = lpfd_pkg::KIND_PAYLOAD;
				res.payload_byte     = din.data_byte;
				res.last_of_message  = (left_q <= 32'd1);
			end
			PH_HEADER: begin
				if (hdr_done) begin
					res_v = 1'b1;
					if (chk.fail) begin
						res.item_kind  = lpfd_pkg::KIND_ERROR;
						res.error_code = chk.code;
					end else begin
						res.item_kind       = lpfd_pkg::KIND_HEADER;
						res.msg_flags       = chk.flags;
						res.msg_type        = chk.msg_type;
						res.req_id          = chk.req_id;
						res.payload_length  = chk.length;
						res.last_of_message = (chk.length == 32'd0);
					end
				end
			end
			default: begin
				res_v = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			left_q   <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
			cfg_q.expected_version <= lpfd_pkg::RST_EXPECTED_VERSION;
			cfg_q.payload_limit    <= lpfd_pkg::RST_PAYLOAD_LIMIT;
			cfg_q.response_bit     <= lpfd_pkg::RST_RESPONSE_BIT;
			cfg_q.error_bit        <= lpfd_pkg::RST_ERROR_BIT;
			cfg_q.stream_bit       <= lpfd_pkg::RST_STREAM_BIT;
			cfg_q.more_bit         <= lpfd_pkg::RST_MORE_BIT;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					lpfd_pkg::REG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_wdata[7:0];
					lpfd_pkg::REG_PAYLOAD_LIMIT:    cfg_q.payload_limit    <= cfg_wdata;
					lpfd_pkg::REG_RESPONSE_BIT:     cfg_q.response_bit     <= cfg_wdata[7:0];
					lpfd_pkg::REG_ERROR_BIT:        cfg_q.error_bit        <= cfg_wdata[7:0];
					lpfd_pkg::REG_STREAM_BIT:       cfg_q.stream_bit       <= cfg_wdata[7:0];
					lpfd_pkg::REG_MORE_BIT:         cfg_q.more_bit         <= cfg_wdata[7:0];
					default: ;
				endcase
			end

			if (in_fire) begin
				case (phase_q)
					PH_PAYLOAD: begin
						if (left_q <= 32'd1) begin
							left_q  <= '0;
							phase_q <= PH_HEADER;
							count_q <= '0;
						end else begin
							left_q <= left_q - 32'd1;
						end
					end
					PH_HEADER: begin
						if (hdr_done) begin
							count_q <= '0;
							if (chk.fail) begin
								phase_q <= PH_BLOCKED;
							end else if (chk.length != 32'd0) begin
								left_q  <= chk.length;
								phase_q <= PH_PAYLOAD;
							end
						end else begin
							count_q <= count_q + 4'd1;
						end
					end
					default: ;
				endcase
			end

			// output queue: main register plus one skid entry
			if (out_v_q && !dout.ready) begin
				if (in_fire && res_v) begin
					skid_v_q <= 1'b1;
				end
			end else if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire && res_v;
			end
		end
	end

	// header store and result data: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && (phase_q == PH_HEADER) && !hdr_done) begin
			store_q <= {store_q[lpfd_pkg::STORE_BITS-9:0], din.data_byte};
		end
		if (out_v_q && !dout.ready) begin
			if (in_fire && res_v) begin
				skid_q <= res;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign dout.valid           = out_v_q;
	assign dout.item_kind       = out_q.item_kind;
	assign dout.msg_flags       = out_q.msg_flags;
	assign dout.msg_type        = out_q.msg_type;
	assign dout.req_id          = out_q.req_id;
	assign dout.payload_length  = out_q.payload_length;
	assign dout.payload_byte    = out_q.payload_byte;
	assign dout.last_of_message = out_q.last_of_message;
	assign dout.error_code      = out_q.error_code;
endmodule
`default_nettype wire

/* rtl/lpfd_checker.sv */
`default_nettype none
module lpfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  item_kind,
	input wire logic [7:0]  msg_flags,
	input wire logic [15:0] msg_type,
	input wire logic [31:0] req_id,
	input wire logic [31:0] payload_length,
	input wire logic        last_of_message
);
	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && item_kind == lpfd_pkg::KIND_ERROR) begin
			err_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_kind != 2'd3)
		else $error("undefined item kind");

	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |-> !out_valid)
		else $error("output after error");

	a_hdr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != lpfd_pkg::KIND_HEADER |->
			msg_flags == 8'd0 && msg_type == 16'd0 && req_id == 32'd0
			&& payload_length == 32'd0)
		else $error("header fields set on non-header word");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == lpfd_pkg::KIND_ERROR |-> !last_of_message)
		else $error("error word marked last");
endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (dout.valid),
	.out_ready       (dout.ready),
	.item_kind       (dout.item_kind),
	.msg_flags       (dout.msg_flags),
	.msg_type        (dout.msg_type),
	.req_id          (dout.req_id),
	.payload_length  (dout.payload_length),
	.last_of_message (dout.last_of_message)
);
`default_nettype wire
